>>> sv/page_frame_stack_allocator_top_macros.svh
// Assertion macros used by the page frame stack allocator top level.
`ifndef PAGE_FRAME_STACK_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk and off during reset.
`define PFSA_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and off during reset.
`define PFSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pfsa_pkg.sv
// Types, codes and default constants of the page frame stack allocator.
`default_nettype none

package pfsa_pkg;

    localparam int ADDR_W      = 64;
    localparam int OP_W        = 2;
    localparam int ERR_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_PC_W    = 13;

    localparam int MAX_PAGES_DEF        = 4096;
    localparam int PAGE_SHIFT_DEF       = 12;
    localparam int BITMAP_WORD_BITS_DEF = 64;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY        = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE        = 2'd2;
    localparam logic [ERR_W-1:0] ERR_ALREADY_FREE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_PAGES = 2'd2;

    localparam logic [CFG_PC_W-1:0] PAGE_COUNT_RESET     = 13'd4096;
    localparam logic [CFG_PC_W-1:0] RESERVED_PAGES_RESET = 13'd1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
    } pfsa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              ok;
        logic              page_free;
        logic [ERR_W-1:0]  error_code;
    } pfsa_out_t;

endpackage

`default_nettype wire

>>> sv/pfsa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module pfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/pfsa_locate.sv
// Maps a physical address to a page number and checks it against the range.
`default_nettype none

module pfsa_locate
    import pfsa_pkg::*;
#(
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int PAGE_W = 12,
    parameter int CNT_W = 13
) (
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [ADDR_W-1:0] range_base,
    input  wire logic [CNT_W-1:0]  range_size,
    output logic                   in_range,
    output logic      [PAGE_W-1:0] page
);

    localparam int PG_W = ADDR_W - PAGE_SHIFT;

    logic [ADDR_W-1:0] offset;
    logic [PG_W-1:0]   page_wide;

    assign offset    = address - range_base;
    assign page_wide = offset[ADDR_W-1:PAGE_SHIFT];
    assign in_range  = (address >= range_base) && (page_wide < PG_W'(range_size));
    assign page      = page_wide[PAGE_W-1:0];

endmodule

`default_nettype wire

>>> sv/page_frame_stack_allocator_top.sv
// Top level of the page frame stack allocator: control, registers and memories.
//
// One transaction is processed at a time. Query and free go through S_BIT (bitmap
// read), alloc through S_PAGE (stack read) and then S_BIT (bitmap read-modify-write),
// and an empty-stack or out-of-range error through S_FIN. Initialize sweeps both
// memories, one stack entry and one bitmap word per cycle, then passes through S_FIN.
// Configuration registers take effect at the next initialize. A result waits in
// an output register, and the next transaction is accepted while it waits.
`default_nettype none

`include "page_frame_stack_allocator_top_macros.svh"

module page_frame_stack_allocator_top
    import pfsa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int BITMAP_WORD_BITS = BITMAP_WORD_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire pfsa_in_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output pfsa_out_t                   m_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PAGE_W   = $clog2(MAX_PAGES);
    localparam int CNT_W    = PAGE_W + 1;
    localparam int BIT_W    = $clog2(BITMAP_WORD_BITS);
    localparam int BM_WORDS = (MAX_PAGES + BITMAP_WORD_BITS - 1) / BITMAP_WORD_BITS;
    localparam int WORD_AW  = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
    localparam int CMP_W    = (CNT_W > CFG_PC_W) ? CNT_W : CFG_PC_W;
    localparam int WB       = BITMAP_WORD_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAGE = 3'd1;
    localparam logic [2:0] S_BIT  = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [CNT_W-1:0]    fc_reg, fc_next;
    logic [ADDR_W-1:0]   range_base_reg, range_base_next;
    logic [CNT_W-1:0]    range_size_reg, range_size_next;
    logic [CNT_W-1:0]    init_res_reg, init_res_next;
    logic [PAGE_W-1:0]   sweep_reg, sweep_next;
    logic [ADDR_W-1:0]   cfg_base_reg;
    logic [CFG_PC_W-1:0] cfg_pc_reg;
    logic [CFG_PC_W-1:0] cfg_res_reg;
    pfsa_out_t           pend_reg, pend_next;
    logic                m_valid_reg, m_valid_next;
    pfsa_out_t           m_data_reg;

    logic                st_we, st_re;
    logic [PAGE_W-1:0]   st_waddr, st_raddr, st_wdata, st_rdata;
    logic                bm_we, bm_re;
    logic [WORD_AW-1:0]  bm_waddr, bm_raddr;
    logic [WB-1:0]       bm_wdata, bm_rdata;

    logic                loc_in_range;
    logic [PAGE_W-1:0]   loc_page;
    logic [CNT_W-1:0]    cfg_size, cfg_resv;
    logic [WB-1:0]       bit_mask, init_mask;
    logic                bit_used;
    logic [CNT_W-1:0]    res_word;
    logic [BIT_W-1:0]    res_lo;
    logic                out_free, out_load;
    pfsa_out_t           out_data;

    pfsa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_PAGES)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    pfsa_ram #(
        .WIDTH (WB),
        .DEPTH (BM_WORDS)
    ) u_bitmap_ram (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    pfsa_locate #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .PAGE_W     (PAGE_W),
        .CNT_W      (CNT_W)
    ) u_locate (
        .address    (s_data.address),
        .range_base (range_base_reg),
        .range_size (range_size_reg),
        .in_range   (loc_in_range),
        .page       (loc_page)
    );

    assign cfg_size = (CMP_W'(cfg_pc_reg) > CMP_W'(MAX_PAGES)) ?
                      CNT_W'(MAX_PAGES) : CNT_W'(cfg_pc_reg);
    assign cfg_resv = (CMP_W'(cfg_res_reg) > CMP_W'(cfg_size)) ?
                      cfg_size : CNT_W'(cfg_res_reg);

    assign bit_mask = WB'(1) << page_reg[BIT_W-1:0];
    assign bit_used = |(bm_rdata & bit_mask);

    assign res_word = init_res_reg >> BIT_W;
    assign res_lo   = init_res_reg[BIT_W-1:0];

    always_comb begin
        if (CNT_W'(sweep_reg) < res_word) begin
            init_mask = '1;
        end else if (CNT_W'(sweep_reg) == res_word) begin
            init_mask = (WB'(1) << res_lo) - WB'(1);
        end else begin
            init_mask = '0;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        fc_next         = fc_reg;
        range_base_next = range_base_reg;
        range_size_next = range_size_reg;
        init_res_next   = init_res_reg;
        sweep_next      = sweep_reg;
        pend_next       = pend_reg;
        st_we           = 1'b0;
        st_waddr        = '0;
        st_wdata        = '0;
        st_re           = 1'b0;
        st_raddr        = '0;
        bm_we           = 1'b0;
        bm_waddr        = '0;
        bm_wdata        = '0;
        bm_re           = 1'b0;
        bm_raddr        = '0;
        out_load        = 1'b0;
        out_data        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_data.op;
                    pend_next = '0;
                    unique case (s_data.op)
                        OP_ALLOC: begin
                            if (fc_reg == '0) begin
                                pend_next.error_code = ERR_EMPTY;
                                state_next           = S_FIN;
                            end else begin
                                st_re      = 1'b1;
                                st_raddr   = PAGE_W'(fc_reg - CNT_W'(1));
                                state_next = S_PAGE;
                            end
                        end
                        OP_FREE, OP_QUERY: begin
                            if (!loc_in_range) begin
                                pend_next.error_code = ERR_RANGE;
                                state_next           = S_FIN;
                            end else begin
                                page_next  = loc_page;
                                bm_re      = 1'b1;
                                bm_raddr   = WORD_AW'(loc_page >> BIT_W);
                                state_next = S_BIT;
                            end
                        end
                        OP_INIT: begin
                            range_base_next = cfg_base_reg;
                            range_size_next = cfg_size;
                            init_res_next   = cfg_resv;
                            fc_next         = cfg_size - cfg_resv;
                            sweep_next      = '0;
                            state_next      = S_INIT;
                        end
                    endcase
                end
            end
            S_PAGE: begin
                page_next  = st_rdata;
                bm_re      = 1'b1;
                bm_raddr   = WORD_AW'(st_rdata >> BIT_W);
                state_next = S_BIT;
            end
            S_BIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    bm_waddr   = WORD_AW'(page_reg >> BIT_W);
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_ALLOC: begin
                            bm_we                 = 1'b1;
                            bm_wdata              = bm_rdata | bit_mask;
                            fc_next               = fc_reg - CNT_W'(1);
                            out_data.ok           = 1'b1;
                            out_data.page_address = range_base_reg +
                                                    (ADDR_W'(page_reg) << PAGE_SHIFT);
                        end
                        OP_FREE: begin
                            if (bit_used && (fc_reg < CNT_W'(MAX_PAGES))) begin
                                bm_we       = 1'b1;
                                bm_wdata    = bm_rdata & ~bit_mask;
                                st_we       = 1'b1;
                                st_waddr    = fc_reg[PAGE_W-1:0];
                                st_wdata    = page_reg;
                                fc_next     = fc_reg + CNT_W'(1);
                                out_data.ok = 1'b1;
                            end else begin
                                out_data.error_code = ERR_ALREADY_FREE;
                            end
                        end
                        OP_QUERY: begin
                            out_data.ok        = 1'b1;
                            out_data.page_free = !bit_used;
                        end
                        OP_INIT: begin
                            out_data.ok = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT: begin
                if (CNT_W'(sweep_reg) < CNT_W'(BM_WORDS)) begin
                    bm_we    = 1'b1;
                    bm_waddr = WORD_AW'(sweep_reg);
                    bm_wdata = init_mask;
                end
                if (CNT_W'(sweep_reg) < fc_reg) begin
                    st_we    = 1'b1;
                    st_waddr = sweep_reg;
                    st_wdata = PAGE_W'(init_res_reg + CNT_W'(sweep_reg));
                end
                if (sweep_reg == PAGE_W'(MAX_PAGES - 1)) begin
                    pend_next    = '0;
                    pend_next.ok = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    sweep_next = sweep_reg + PAGE_W'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_data   = pend_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fc_reg         <= '0;
            range_base_reg <= '0;
            range_size_reg <= '0;
            m_valid_reg    <= 1'b0;
            cfg_base_reg   <= '0;
            cfg_pc_reg     <= PAGE_COUNT_RESET;
            cfg_res_reg    <= RESERVED_PAGES_RESET;
        end else begin
            state_reg      <= state_next;
            fc_reg         <= fc_next;
            range_base_reg <= range_base_next;
            range_size_reg <= range_size_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BASE_ADDRESS: begin
                        cfg_base_reg <= cfg_data;
                    end
                    CFG_PAGE_COUNT: begin
                        cfg_pc_reg <= cfg_data[CFG_PC_W-1:0];
                    end
                    CFG_RESERVED_PAGES: begin
                        cfg_res_reg <= cfg_data[CFG_PC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        page_reg       <= page_next;
        init_res_reg   <= init_res_next;
        sweep_reg      <= sweep_next;
        pend_reg       <= pend_next;
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PFSA_ASSERT(a_fc_bound, 1'b1, fc_reg <= CNT_W'(MAX_PAGES), "free count above capacity")
    `PFSA_ASSERT(a_idle_no_write, state_reg == S_IDLE, !bm_we && !st_we, "memory write while idle")
    `PFSA_ASSERT_NEXT(a_alloc_pop, state_reg == S_BIT && out_load && op_reg == OP_ALLOC, fc_reg == $past(fc_reg) - CNT_W'(1), "alloc did not pop the stack")
    `PFSA_ASSERT(a_init_count, state_reg == S_INIT, fc_reg <= range_size_reg, "initial free count above range size")

endmodule

`default_nettype wire

>>> sim/tb_page_frame_stack_allocator_top.sv
// Self-checking testbench for the page frame stack allocator, with its own allocator predictor.
`timescale 1ns / 1ps

module tb_page_frame_stack_allocator_top
    import pfsa_pkg::*;
();

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    pfsa_in_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    pfsa_out_t              m_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BASE_ADDRESS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    page_frame_stack_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Register copies and allocator state of the predictor.
    logic [63:0]         reg_base = '0;
    logic [CFG_PC_W-1:0] reg_count = PAGE_COUNT_RESET;
    logic [CFG_PC_W-1:0] reg_reserved = RESERVED_PAGES_RESET;
    logic [11:0]         free_pages [MAX_PAGES_DEF];
    bit                  page_used [MAX_PAGES_DEF];
    int                  free_depth = 0;
    logic [63:0]         span_base = '0;
    int                  span_pages = 0;

    // Range the stimulus aims at.
    logic [63:0] gen_base = '0;
    int          gen_pages = 0;

    pfsa_in_t  requests_pending [$];
    pfsa_out_t outcomes_due [$];
    pfsa_out_t oldest;
    bit        calm = 1'b0;
    bit        in_fire = 1'b0;
    int        launched = 0;
    int        accepted = 0;
    int        failures = 0;
    int        n_granted = 0;
    int        n_refused = 0;
    int        n_returned = 0;
    int        n_queries = 0;
    int        n_inits = 0;
    int        n_settings = 1;

    function automatic bit locate_page(input logic [63:0] addr, output int page);
        logic [63:0] pg;
        if (addr < span_base)
            return 1'b0;
        pg = (addr - span_base) >> PAGE_SHIFT_DEF;
        if (pg >= 64'(span_pages))
            return 1'b0;
        page = int'(pg);
        return 1'b1;
    endfunction

    function automatic pfsa_out_t allocator_outcome(input pfsa_in_t req);
        pfsa_out_t res;
        int        page;
        int        size;
        int        rsv;
        int        p;
        res = '0;
        page = 0;
        case (req.op)
            OP_ALLOC: begin
                if (free_depth == 0) begin
                    res.error_code = ERR_EMPTY;
                    n_refused++;
                end else begin
                    free_depth--;
                    page = int'(free_pages[free_depth]);
                    page_used[page] = 1'b1;
                    res.page_address = span_base + (64'(page) << PAGE_SHIFT_DEF);
                    res.ok = 1'b1;
                    n_granted++;
                end
            end
            OP_FREE: begin
                if (!locate_page(req.address, page)) begin
                    res.error_code = ERR_RANGE;
                end else if (!page_used[page] || free_depth >= MAX_PAGES_DEF) begin
                    res.error_code = ERR_ALREADY_FREE;
                end else begin
                    free_pages[free_depth] = 12'(page);
                    free_depth++;
                    page_used[page] = 1'b0;
                    res.ok = 1'b1;
                    n_returned++;
                end
            end
            OP_QUERY: begin
                n_queries++;
                if (!locate_page(req.address, page)) begin
                    res.error_code = ERR_RANGE;
                end else begin
                    res.page_free = !page_used[page];
                    res.ok = 1'b1;
                end
            end
            default: begin
                size = (reg_count > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(reg_count);
                rsv = (reg_reserved > size) ? size : int'(reg_reserved);
                for (p = 0; p < MAX_PAGES_DEF; p++)
                    page_used[p] = (p < rsv);
                free_depth = 0;
                for (p = rsv; p < size; p++) begin
                    free_pages[free_depth] = 12'(p);
                    free_depth++;
                end
                span_base = reg_base;
                span_pages = size;
                res.ok = 1'b1;
                n_inits++;
            end
        endcase
        return res;
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            failures++;
        end
    endfunction

    function automatic pfsa_in_t random_item();
        pfsa_in_t    item;
        int unsigned r;
        int unsigned pg;
        logic [63:0] offs;
        r = $urandom_range(99);
        item.address = {$urandom, $urandom};
        pg = $urandom_range(gen_pages);
        if ($urandom_range(1) == 1 && gen_pages > 64)
            pg = gen_pages - 1 - $urandom_range(63);
        case ($urandom_range(2))
            0: offs = '0;
            1: offs = 64'hFFF;
            default: offs = 64'($urandom_range(4095));
        endcase
        if (r < 1) begin
            item.op = OP_INIT;
        end else if (r < 38) begin
            item.op = OP_ALLOC;
        end else if (r < 92) begin
            item.op = (r < 70) ? OP_FREE : OP_QUERY;
            item.address = gen_base + (64'(pg) << PAGE_SHIFT_DEF) + offs;
        end else begin
            item.op = r[0] ? OP_FREE : OP_QUERY;
            if (r >= 97)
                item.address = gen_base - 64'($urandom_range(4096, 1));
        end
        return item;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: result with no transaction pending, actual %h", $time, m_data);
                    failures++;
                end else begin
                    oldest = outcomes_due.pop_front();
                    compare_field("page_address", oldest.page_address, m_data.page_address);
                    compare_field("ok", 64'(oldest.ok), 64'(m_data.ok));
                    compare_field("page_free", 64'(oldest.page_free), 64'(m_data.page_free));
                    compare_field("error_code", 64'(oldest.error_code), 64'(m_data.error_code));
                end
            end
            in_fire = s_valid && s_ready;
            if (in_fire) begin
                outcomes_due.push_back(allocator_outcome(s_data));
                accepted++;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= calm || ($urandom_range(99) >= 23);
            if (!s_valid || in_fire) begin
                if (requests_pending.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
                    s_valid <= 1'b1;
                    s_data <= requests_pending.pop_front();
                    launched++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic drain();
        while (requests_pending.size() != 0 || launched != accepted || outcomes_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_BASE_ADDRESS: reg_base = value;
            CFG_PAGE_COUNT: reg_count = value[CFG_PC_W-1:0];
            default: reg_reserved = value[CFG_PC_W-1:0];
        endcase
    endtask

    task automatic run_phase(input logic [63:0] base, input logic [63:0] count_word,
                             input logic [63:0] reserved_word, input int items, input bit quiet);
        pfsa_in_t init_req;
        int       k;
        drain();
        calm = 1'b0;
        write_reg(CFG_BASE_ADDRESS, base);
        write_reg(CFG_PAGE_COUNT, count_word);
        write_reg(CFG_RESERVED_PAGES, reserved_word);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        gen_base = reg_base;
        gen_pages = (reg_count > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(reg_count);
        n_settings++;
        calm = quiet;
        init_req.op = OP_INIT;
        init_req.address = {$urandom, $urandom};
        requests_pending.push_back(init_req);
        for (k = 0; k < items; k++)
            requests_pending.push_back(random_item());
    endtask

    function automatic pfsa_in_t make_req(input logic [OP_W-1:0] op, input logic [63:0] addr);
        pfsa_in_t req;
        req.op = op;
        req.address = addr;
        return req;
    endfunction

    initial begin
        for (int p = 0; p < MAX_PAGES_DEF; p++) begin
            page_used[p] = 1'b0;
            free_pages[p] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Power-up range is empty until the first initialize; defaults follow.
        requests_pending.push_back(make_req(OP_ALLOC, 64'h0));
        requests_pending.push_back(make_req(OP_FREE, 64'h0));
        requests_pending.push_back(make_req(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF));
        requests_pending.push_back(make_req(OP_INIT, 64'h0));
        requests_pending.push_back(make_req(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF));
        requests_pending.push_back(make_req(OP_QUERY, 64'h0000_0000_00FF_F000));
        requests_pending.push_back(make_req(OP_FREE, 64'h0000_0000_00FF_F123));
        requests_pending.push_back(make_req(OP_FREE, 64'h0000_0000_00FF_F000));
        requests_pending.push_back(make_req(OP_QUERY, 64'h0000_0000_00FF_FFFF));
        requests_pending.push_back(make_req(OP_QUERY, 64'h0));
        requests_pending.push_back(make_req(OP_FREE, 64'h0000_0000_0000_0ABC));
        requests_pending.push_back(make_req(OP_ALLOC, 64'h0));
        requests_pending.push_back(make_req(OP_FREE, 64'h0000_0000_0100_0000));
        requests_pending.push_back(make_req(OP_ALLOC, 64'h0));

        run_phase(64'h0000_0001_2345_6000, 64'd16, 64'd2, 200, 1'b0);
        run_phase(64'hFFFF_FFFF_FFFF_0000, {$urandom, $urandom} | 64'h1FFF,
                  64'd4, 150, 1'b0);
        run_phase({$urandom, $urandom}, 64'd0, 64'd1, 60, 1'b0);
        run_phase(64'h0, 64'd5, 64'd9, 80, 1'b0);
        run_phase({$urandom, $urandom} & ~64'hFFF, 64'd64, 64'd0, 250, 1'b1);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd0, 80, 1'b0);
        run_phase({$urandom, $urandom}, 64'd4096, 64'd4096, 80, 1'b0);
        run_phase({$urandom, $urandom} & ~64'hFFF, 64'($urandom_range(300, 2)),
                  64'($urandom_range(8)), 300, 1'b0);
        run_phase({$urandom, $urandom}, 64'd4096, 64'd1, 300, 1'b0);
        run_phase({$urandom, $urandom} & ~64'hFFF, 64'd32, 64'd1, 250, 1'b0);

        drain();
        calm = 1'b0;
        repeat (10) @(posedge aclk);
        $display("Ran %0d transactions over %0d register settings, %0d of them initializations.",
                 accepted, n_settings, n_inits);
        $display("Pages granted %0d, refused for an empty stack %0d, returned %0d; queries %0d.",
                 n_granted, n_refused, n_returned, n_queries);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding.", outcomes_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> page_frame_stack_allocator_top.f
+incdir+sv
sv/pfsa_pkg.sv
sv/pfsa_ram.sv
sv/pfsa_locate.sv
sv/page_frame_stack_allocator_top.sv
sim/tb_page_frame_stack_allocator_top.sv
